[src/rsc_pkg.sv]
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, codes and helpers for the RPN stack calculator.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int DATA_W        = 32;
	localparam int COUNT_OUT_W   = 5;

	// action codes of an input item
	typedef enum logic [2:0] {
		ACT_PUSH  = 3'd0,
		ACT_ADD   = 3'd1,
		ACT_SUB   = 3'd2,
		ACT_MUL   = 3'd3,
		ACT_DIV   = 3'd4,
		ACT_SQRT  = 3'd5,
		ACT_CLEAR = 3'd6
	} action_t;

	// status codes of a result
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FEW     = 3'd1,
		ST_DIVZERO = 3'd2,
		ST_COMPLEX = 3'd3,
		ST_FULL    = 3'd4,
		ST_INVALID = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_EXEC,
		S_MUL,
		S_ITER,
		S_POP,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;     // sample push value at accept
		logic push;
		logic clear;
		logic rd_next;     // read entry below top
		logic alu_commit;  // add/sub result replaces the two operands
		logic alu_sub;
		logic mul_cap;     // register the raw product
		logic mul_commit;
		logic iter_start;
		logic iter_commit;
		logic is_div;      // iterative unit: divide, else square root
		logic pop;         // drop top, next becomes top
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic lt2;
		logic full;
		logic fill_last;
		logic top_neg;
		logic top_zero;
		logic iter_done;
	} dp_stat_t;

	// saturate to signed 32 bits
	function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic [DATA_W-1:0] r;
		if (v > 64'sd2147483647)
			r = 32'h7FFF_FFFF;
		else if (v < -64'sd2147483648)
			r = 32'h8000_0000;
		else
			r = v[DATA_W-1:0];
		return r;
	endfunction

endpackage

[src/rsc_iter.sv]
// ----------------------------------------------------------------------------
// rsc_iter
// Shared iterative unit: Q16.16 divide (one quotient bit per cycle, 48 steps)
// and Q16.16 square root (one root bit per cycle, 24 steps).
// ----------------------------------------------------------------------------
module rsc_iter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      is_div,
	input  logic [rsc_pkg::DATA_W-1:0] a,
	input  logic [rsc_pkg::DATA_W-1:0] b,
	output logic                      done,
	output logic [rsc_pkg::DATA_W-1:0] result
);

	logic        busy_q, done_q, div_q, neg_q;
	logic [5:0]  cnt_q;
	logic [47:0] sh_q;
	logic [33:0] rem_q;
	logic [47:0] quo_q;
	logic [31:0] den_q;

	logic [31:0] abs_a, abs_b;
	logic [33:0] r_div, r_sqrt, trial;
	logic signed [48:0] qv;

	assign abs_a = a[31] ? (~a + 32'd1) : a;
	assign abs_b = b[31] ? (~b + 32'd1) : b;

	// partial remainders for this step
	assign r_div  = {rem_q[32:0], sh_q[47]};
	assign r_sqrt = {rem_q[31:0], sh_q[47:46]};
	assign trial  = {quo_q[31:0], 2'b01};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= is_div ? 6'd48 : 6'd24;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath of the recurrence
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			neg_q <= a[31] ^ b[31];
			sh_q  <= is_div ? {abs_a, 16'h0000} : {a, 16'h0000};
			den_q <= abs_b;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			if (div_q) begin
				sh_q <= {sh_q[46:0], 1'b0};
				if (r_div >= {2'b00, den_q}) begin
					rem_q <= r_div - {2'b00, den_q};
					quo_q <= {quo_q[46:0], 1'b1};
				end else begin
					rem_q <= r_div;
					quo_q <= {quo_q[46:0], 1'b0};
				end
			end else begin
				sh_q <= {sh_q[45:0], 2'b00};
				if (r_sqrt >= trial) begin
					rem_q <= r_sqrt - trial;
					quo_q <= {quo_q[46:0], 1'b1};
				end else begin
					rem_q <= r_sqrt;
					quo_q <= {quo_q[46:0], 1'b0};
				end
			end
		end
	end

	// sign and saturation of the quotient
	assign qv     = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign result = div_q ? rsc_pkg::sat32(64'(qv)) : quo_q[31:0];
	assign done   = done_q;

endmodule

[src/rsc_datapath.sv]
// ----------------------------------------------------------------------------
// rsc_datapath
// Stack memory with the top entry held in a register, entry count, the
// add/subtract and multiply units and the shared divide/root unit.
// ----------------------------------------------------------------------------
module rsc_datapath #(
	parameter int STACK_DEPTH = rsc_pkg::DEPTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [rsc_pkg::DATA_W-1:0]      push_value,
	input  rsc_pkg::dp_cmd_t               cmd,
	output rsc_pkg::dp_stat_t              stat,
	output logic [rsc_pkg::DATA_W-1:0]      top_value,
	output logic [rsc_pkg::COUNT_OUT_W-1:0] entry_count
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [rsc_pkg::DATA_W-1:0] mem [STACK_DEPTH];
	logic [rsc_pkg::DATA_W-1:0] val_q, top_q, rd_q;
	logic [CW-1:0]              count_q, cnt_m1, cnt_m2;
	logic signed [63:0]         prod_q;
	logic signed [32:0]         alu_sum;
	logic [CW+rsc_pkg::COUNT_OUT_W-1:0] cnt_ext;
	logic                       iter_done;
	logic [rsc_pkg::DATA_W-1:0] iter_res, iter_a;

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);

	// stack memory: spill of the old top on push, read of the entry below top
	always_ff @(posedge clk) begin
		if (cmd.push && count_q != '0)
			mem[cnt_m1[AW-1:0]] <= top_q;
		if (cmd.rd_next)
			rd_q <= mem[cnt_m2[AW-1:0]];
	end

	// add / subtract of next and top
	assign alu_sum = cmd.alu_sub ? ($signed({rd_q[31], rd_q}) - $signed({top_q[31], top_q}))
	                             : ($signed({rd_q[31], rd_q}) + $signed({top_q[31], top_q}));

	assign iter_a = cmd.is_div ? rd_q : top_q;

	rsc_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.iter_start),
		.is_div (cmd.is_div),
		.a      (iter_a),
		.b      (top_q),
		.done   (iter_done),
		.result (iter_res)
	);

	// operand and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture)
			val_q <= push_value;
		if (cmd.mul_cap)
			prod_q <= $signed(rd_q) * $signed(top_q);
		if (cmd.push)
			top_q <= val_q;
		else if (cmd.alu_commit)
			top_q <= rsc_pkg::sat32(64'(alu_sum));
		else if (cmd.mul_commit)
			top_q <= rsc_pkg::sat32(prod_q >>> 16);
		else if (cmd.iter_commit)
			top_q <= iter_res;
		else if (cmd.pop)
			top_q <= rd_q;
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.alu_commit || cmd.mul_commit || cmd.pop
		             || (cmd.iter_commit && cmd.is_div)) begin
			count_q <= cnt_m1;
		end
	end

	assign stat.empty     = (count_q == '0);
	assign stat.lt2       = (count_q < CW'(2));
	assign stat.full      = (count_q >= CW'(STACK_DEPTH));
	assign stat.fill_last = (count_q == CW'(STACK_DEPTH - 1));
	assign stat.top_neg   = top_q[31];
	assign stat.top_zero  = (top_q == '0);
	assign stat.iter_done = iter_done;

	assign cnt_ext     = (CW + rsc_pkg::COUNT_OUT_W)'(count_q);
	assign entry_count = cnt_ext[rsc_pkg::COUNT_OUT_W-1:0];
	assign top_value   = (count_q == '0) ? '0 : top_q;

endmodule

[src/rsc_ctrl.sv]
// ----------------------------------------------------------------------------
// rsc_ctrl
// Controller: accepts an action, checks the stack, sequences the datapath
// and raises the result strobe with the status code.
// ----------------------------------------------------------------------------
module rsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        action,
	input  rsc_pkg::dp_stat_t stat,
	output rsc_pkg::dp_cmd_t  cmd,
	output logic              busy,
	output logic              done,
	output logic [2:0]        status
);

	rsc_pkg::state_t  state_q, state_d;
	rsc_pkg::status_t status_q, status_d;
	logic [2:0]       act_q;

	// state, action and status registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rsc_pkg::S_IDLE;
			status_q <= rsc_pkg::ST_OK;
			act_q    <= '0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (state_q == rsc_pkg::S_IDLE && start)
				act_q <= action;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		cmd        = '0;
		cmd.is_div = (act_q == rsc_pkg::ACT_DIV);
		cmd.alu_sub = (act_q == rsc_pkg::ACT_SUB);
		case (state_q)
			rsc_pkg::S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					status_d    = rsc_pkg::ST_OK;
					state_d     = rsc_pkg::S_DECIDE;
				end
			end
			rsc_pkg::S_DECIDE: begin
				state_d = rsc_pkg::S_DONE;
				case (act_q)
					rsc_pkg::ACT_PUSH: begin
						if (stat.full) begin
							status_d = rsc_pkg::ST_FULL;
						end else begin
							cmd.push = 1'b1;
							if (stat.fill_last)
								status_d = rsc_pkg::ST_FULL;
						end
					end
					rsc_pkg::ACT_ADD, rsc_pkg::ACT_SUB, rsc_pkg::ACT_MUL,
					rsc_pkg::ACT_DIV: begin
						if (stat.lt2) begin
							status_d = rsc_pkg::ST_FEW;
						end else if (act_q == rsc_pkg::ACT_DIV && stat.top_zero) begin
							status_d = rsc_pkg::ST_DIVZERO;
						end else begin
							cmd.rd_next = 1'b1;
							state_d     = rsc_pkg::S_EXEC;
						end
					end
					rsc_pkg::ACT_SQRT: begin
						if (stat.empty) begin
							status_d = rsc_pkg::ST_FEW;
						end else if (stat.top_neg) begin
							// drop the negative value, fetch what lies below
							status_d    = rsc_pkg::ST_COMPLEX;
							cmd.rd_next = 1'b1;
							state_d     = rsc_pkg::S_POP;
						end else begin
							cmd.iter_start = 1'b1;
							state_d        = rsc_pkg::S_ITER;
						end
					end
					rsc_pkg::ACT_CLEAR: begin
						if (stat.empty)
							status_d = rsc_pkg::ST_INVALID;
						else
							cmd.clear = 1'b1;
					end
					default: begin
						status_d = rsc_pkg::ST_INVALID;
					end
				endcase
			end
			rsc_pkg::S_EXEC: begin
				case (act_q)
					rsc_pkg::ACT_MUL: begin
						cmd.mul_cap = 1'b1;
						state_d     = rsc_pkg::S_MUL;
					end
					rsc_pkg::ACT_DIV: begin
						cmd.iter_start = 1'b1;
						state_d        = rsc_pkg::S_ITER;
					end
					default: begin
						cmd.alu_commit = 1'b1;
						state_d        = rsc_pkg::S_DONE;
					end
				endcase
			end
			rsc_pkg::S_MUL: begin
				cmd.mul_commit = 1'b1;
				state_d        = rsc_pkg::S_DONE;
			end
			rsc_pkg::S_ITER: begin
				if (stat.iter_done) begin
					cmd.iter_commit = 1'b1;
					state_d         = rsc_pkg::S_DONE;
				end
			end
			rsc_pkg::S_POP: begin
				cmd.pop = 1'b1;
				state_d = rsc_pkg::S_DONE;
			end
			rsc_pkg::S_DONE: begin
				state_d = rsc_pkg::S_IDLE;
			end
			default: begin
				state_d = rsc_pkg::S_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != rsc_pkg::S_IDLE);
	assign done   = (state_q == rsc_pkg::S_DONE);
	assign status = status_q;

endmodule

[src/rpn_stack_calculator.sv]
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish calculator on signed Q16.16 values with a hardware stack.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive action and push_value with start high; the transfer takes
//   place at a rising edge where start is high and busy is low. busy then
//   stays high until the result has been shown.
//   Output: done is high for exactly one cycle; status, top_value and
//   entry_count are valid in that cycle. The receiver cannot stall the block.
//   Each action runs from the accept through a decide state to done. Add
//   and subtract pass an execute state; multiply an execute and a product
//   state; a negative square root a pop state; square root the shared
//   iterative unit (one root bit per cycle over 24 bits); divide an execute
//   state and that unit (one quotient bit per cycle over 48 bits). A new
//   item may be accepted in the cycle after done.
//   Reset (arst_n low) empties the stack and returns the controller to idle;
//   stack memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = rsc_pkg::DEPTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [2:0]                     action,
	input  logic signed [rsc_pkg::DATA_W-1:0] push_value,
	output logic                           done,
	output logic [2:0]                     status,
	output logic signed [rsc_pkg::DATA_W-1:0] top_value,
	output logic [rsc_pkg::COUNT_OUT_W-1:0] entry_count
);

	rsc_pkg::dp_cmd_t  cmd;
	rsc_pkg::dp_stat_t stat;

	rsc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.status (status)
	);

	rsc_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_value  (push_value),
		.cmd         (cmd),
		.stat        (stat),
		.top_value   (top_value),
		.entry_count (entry_count)
	);

	// an accepted transfer always makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// the result strobe is followed by idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result");

	// a push never takes the stack past its depth
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !stat.full)
		else $error("push onto full stack");

	// a divide is never started with a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.iter_start && cmd.is_div) |-> !stat.top_zero)
		else $error("divide started with zero divisor");

endmodule

[verif/rpn_stack_calculator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_test
// Drives random and directed calculator actions, predicts status, top value
// and entry count with a local model of the stack and checks every result.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_test;

	localparam int DEPTH = 16;
	// action code with no operation behind it
	localparam logic [2:0] ACT_RESERVED = 3'd7;

	typedef struct {
		logic [2:0]  act;
		logic [31:0] val;
	} calc_op_t;

	typedef struct {
		logic [2:0]  st;
		logic [31:0] top;
		logic [4:0]  cnt;
	} calc_res_t;

	logic        clk;
	logic        arst_n;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  action = rsc_pkg::ACT_PUSH;
	logic signed [31:0] push_value = '0;
	logic        done;
	logic [2:0]  status;
	logic signed [31:0] top_value;
	logic [4:0]  entry_count;

	calc_op_t  pending_ops[$];
	calc_res_t expected_results[$];
	logic [31:0] model_stack[DEPTH];
	int          model_count = 0;
	int          error_count = 0;
	int          gap_left = 0;
	logic        busy_at_rise;

	rpn_stack_calculator #(.STACK_DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .push_value(push_value), .done(done),
		.status(status), .top_value(top_value), .entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// saturate to signed 32 bits
	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [31:0] fix_mul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return clamp32(p >>> 16);   // arithmetic shift floors
	endfunction

	function automatic logic [31:0] fix_div(input logic signed [31:0] n,
			input logic signed [31:0] d);
		longint q;
		q = (longint'(n) * 65536) / longint'(d);
		return clamp32(q);
	endfunction

	function automatic logic [31:0] fix_root(input logic [31:0] x);
		logic [63:0] v, root, b;
		v = {16'd0, x, 16'd0};
		root = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v = v - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root[31:0];
	endfunction

	// apply one action to the local stack, return the expected result
	function automatic calc_res_t calc_step(input calc_op_t op);
		calc_res_t r;
		logic signed [31:0] t, n;
		logic [31:0] v;
		r.st = rsc_pkg::ST_OK;
		case (op.act)
			rsc_pkg::ACT_PUSH: begin
				if (model_count >= DEPTH) begin
					r.st = rsc_pkg::ST_FULL;
				end else begin
					model_stack[model_count] = op.val;
					model_count++;
					if (model_count == DEPTH)
						r.st = rsc_pkg::ST_FULL;
				end
			end
			rsc_pkg::ACT_ADD, rsc_pkg::ACT_SUB, rsc_pkg::ACT_MUL,
			rsc_pkg::ACT_DIV: begin
				if (model_count < 2) begin
					r.st = rsc_pkg::ST_FEW;
				end else begin
					t = model_stack[model_count-1];
					n = model_stack[model_count-2];
					if (op.act == rsc_pkg::ACT_DIV && t == 0) begin
						r.st = rsc_pkg::ST_DIVZERO;
					end else begin
						case (op.act)
							rsc_pkg::ACT_ADD: v = clamp32(longint'(n) + longint'(t));
							rsc_pkg::ACT_SUB: v = clamp32(longint'(n) - longint'(t));
							rsc_pkg::ACT_MUL: v = fix_mul(n, t);
							default: v = fix_div(n, t);
						endcase
						model_count--;
						model_stack[model_count-1] = v;
					end
				end
			end
			rsc_pkg::ACT_SQRT: begin
				if (model_count == 0) begin
					r.st = rsc_pkg::ST_FEW;
				end else if (model_stack[model_count-1][31]) begin
					model_count--;
					r.st = rsc_pkg::ST_COMPLEX;
				end else begin
					model_stack[model_count-1] = fix_root(model_stack[model_count-1]);
				end
			end
			rsc_pkg::ACT_CLEAR: begin
				if (model_count == 0)
					r.st = rsc_pkg::ST_INVALID;
				else
					model_count = 0;
			end
			default: r.st = rsc_pkg::ST_INVALID;
		endcase
		r.top = model_count ? model_stack[model_count-1] : 32'd0;
		r.cnt = model_count[4:0];
		return r;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 1) ? 32'd0 : 32'd65536;
			3: return {{16{1'b0}}, 16'($urandom)} - 32'h0000_8000;
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 3) == 0)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(0, 3);
	endfunction

	task automatic queue_op(input logic [2:0] a, input logic [31:0] v);
		calc_op_t op;
		op.act = a;
		op.val = v;
		pending_ops.push_back(op);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on %s: got %h, expected %h", what, got, want);
		error_count++;
	endtask

	// busy as seen at the last rising edge
	always @(posedge clk)
		busy_at_rise <= busy;

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy_at_rise) begin
				// item taken at the last rising edge
				start <= 1'b0;
				gap_left <= rand_gap();
			end else if (!start && pending_ops.size() != 0) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else begin
					calc_op_t op;
					op = pending_ops.pop_front();
					expected_results.push_back(calc_step(op));
					action <= op.act;
					push_value <= op.val;
					start <= 1'b1;
				end
			end
		end
	end

	// monitor: compare every result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("result with nothing expected");
				error_count++;
			end else begin
				calc_res_t e;
				e = expected_results.pop_front();
				if (status !== e.st)
					report_mismatch("status", 32'(status), 32'(e.st));
				if (top_value !== e.top)
					report_mismatch("top_value", top_value, e.top);
				if (entry_count !== e.cnt)
					report_mismatch("entry_count", 32'(entry_count), 32'(e.cnt));
			end
		end
	end

	initial begin
		int wd;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty-stack cases, extremes, saturation, special cases
		queue_op(rsc_pkg::ACT_ADD, 0);
		queue_op(rsc_pkg::ACT_SQRT, 0);
		queue_op(rsc_pkg::ACT_CLEAR, 0);
		queue_op(ACT_RESERVED, 0);
		queue_op(rsc_pkg::ACT_PUSH, 32'h7FFF_FFFF);
		queue_op(rsc_pkg::ACT_DIV, 0);
		queue_op(rsc_pkg::ACT_PUSH, 32'h7FFF_FFFF);
		queue_op(rsc_pkg::ACT_ADD, 0);
		queue_op(rsc_pkg::ACT_PUSH, 32'h8000_0000);
		queue_op(rsc_pkg::ACT_SUB, 0);
		queue_op(rsc_pkg::ACT_PUSH, 32'd0);
		queue_op(rsc_pkg::ACT_DIV, 0);
		queue_op(rsc_pkg::ACT_CLEAR, 0);
		queue_op(rsc_pkg::ACT_PUSH, 32'h8000_0000);
		queue_op(rsc_pkg::ACT_PUSH, 32'h8000_0000);
		queue_op(rsc_pkg::ACT_MUL, 0);
		queue_op(rsc_pkg::ACT_PUSH, 32'h0000_0001);
		queue_op(rsc_pkg::ACT_DIV, 0);
		queue_op(rsc_pkg::ACT_SQRT, 0);
		queue_op(rsc_pkg::ACT_PUSH, 32'hFFFF_0000);
		queue_op(rsc_pkg::ACT_SQRT, 0);
		for (int i = 0; i < DEPTH + 1; i++)
			queue_op(rsc_pkg::ACT_PUSH, 32'(i) << 15);
		queue_op(rsc_pkg::ACT_CLEAR, 0);

		// random: mostly push-heavy well-formed sequences, some noise
		for (int i = 0; i < 1100; i++) begin
			int k;
			k = $urandom_range(0, 99);
			if (k < 40)
				queue_op(rsc_pkg::ACT_PUSH, rand_value());
			else if (k < 92)
				queue_op(3'($urandom_range(1, 5)), $urandom);
			else if (k < 96)
				queue_op(rsc_pkg::ACT_CLEAR, $urandom);
			else
				queue_op(ACT_RESERVED, $urandom);
		end

		wd = 0;
		while ((pending_ops.size() != 0 || expected_results.size() != 0 || start)
				&& wd < 1000000) begin
			@(posedge clk);
			wd++;
		end
		repeat (60) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0
				&& pending_ops.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// run limit
	initial begin
		#8000000;
		$display("FAILURE");
		$finish;
	end

endmodule
